>>> design/pstb_pkg.sv
// Shared types and constants for the periodic software timer bank.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pstb_pkg;

  // Operation codes as they arrive on the input channel.
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_STOP_ALL = 3'd3,
    OP_QUERY    = 3'd4
  } op_code_t;

  // Width of the result masks; only the first four timers are reported there.
  localparam int MASK_BITS = 4;

  // Bit steps taken by the remainder unit for a 32-bit dividend.
  localparam int DIV_STEPS = 32;

  // Entries in the command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    op_code_t    op;
    logic [1:0]  idx;
    logic        idx_ok;
    logic [15:0] period;
    logic        restart;
  } cmd_t;

endpackage

`default_nettype wire

>>> design/periodic_software_timer_bank.sv
// Top level of the periodic software timer bank: front end, command queue and
// back end wired together. Uses pstb_pkg, pstb_front, pstb_queue and pstb_back.
//
// Usage. Each input beat (in_valid high, in_stall low) carries one operation:
// a tick, a start with period and optional count restart, a stop, a stop of
// all timers, or a query; codes five to seven are treated as a query. Every
// input beat produces exactly one output beat, in order, holding the fired
// mask of a tick, the stopped mask, the all-stopped flag, the remaining ticks
// of the addressed timer and the global tick count, all as they stand after
// the operation.
// Flow. The back end handles one command at a time; a shared bit-serial
// remainder unit carries out each division. A start, stop or query divides
// once for the remaining ticks of the addressed timer, and skips it when the
// addressed timer has a zero period. A tick walks every timer: a stopped or
// idle timer is stepped past, a running timer with a nonzero period and count
// takes a division. The front register and a two-entry queue keep accepting
// beats while the back end works, so up to three commands may be waiting.
// Reset (rst_n low, synchronous) stops every timer, clears all counts, periods
// and the tick total, and empties the queue and the result register. When the
// receiver stalls, the result register holds its beat and the back end waits;
// the queue then fills and in_stall rises towards the sender.
`default_nettype none

module periodic_software_timer_bank #(
  parameter int TIMER_COUNT = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_op,
  input  wire logic [1:0]  in_timer_index,
  input  wire logic [15:0] in_new_period,
  input  wire logic        in_restart_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_fired_mask,
  output logic [3:0]       out_stopped_mask,
  output logic             out_all_stopped,
  output logic [15:0]      out_eta_ticks,
  output logic [31:0]      out_tick_total
);
  import pstb_pkg::*;

  // Mask bits that belong to timers which exist in this bank.
  localparam logic [MASK_BITS-1:0] LIVE_MASK = MASK_BITS'((64'd1 << TIMER_COUNT) - 64'd1);

  logic push_valid;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_head;

  // Front end: registers and classifies each accepted beat.
  pstb_front #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_timer_index   (in_timer_index),
    .in_new_period    (in_new_period),
    .in_restart_count (in_restart_count),
    .push_valid       (push_valid),
    .push_cmd         (push_cmd),
    .q_full           (q_full)
  );

  // The queue lets the front keep taking beats while the back end is busy.
  pstb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .q_full     (q_full),
    .pop        (q_pop),
    .q_empty    (q_empty),
    .q_head     (q_head)
  );

  // Back end: owns the timer state and the result register.
  pstb_back #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fired_mask   (out_fired_mask),
    .out_stopped_mask (out_stopped_mask),
    .out_all_stopped  (out_all_stopped),
    .out_eta_ticks    (out_eta_ticks),
    .out_tick_total   (out_tick_total)
  );

  // A timer that fired on a tick is running, so it cannot also read as stopped.
  a_fired_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_fired_mask & out_stopped_mask) == '0))
    else $error("fired timer reported as stopped");

  // When all timers are stopped, every reported timer must show as stopped.
  a_all_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_all_stopped) |-> ((out_stopped_mask | ~LIVE_MASK) == '1))
    else $error("all_stopped disagrees with stopped mask");

  // Reset leaves both channels empty and the input side open.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!in_stall && !out_valid))
    else $error("channels not clear after reset");

endmodule

`default_nettype wire

>>> design/pstb_front.sv
// Front end of the timer bank: accepts input beats, classifies the operation
// and range-checks the index, then hands the command to the queue. Uses pstb_pkg.
`default_nettype none

module pstb_front #(
  parameter int TIMER_COUNT = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [2:0]     in_op,
  input  wire logic [1:0]     in_timer_index,
  input  wire logic [15:0]    in_new_period,
  input  wire logic           in_restart_count,
  output logic                push_valid,
  output pstb_pkg::cmd_t      push_cmd,
  input  wire logic           q_full
);
  import pstb_pkg::*;

  logic front_valid_r, front_valid_nxt;
  cmd_t front_cmd_r, front_cmd_nxt;
  cmd_t decoded;
  logic accept;
  logic push;

  always_comb begin
    decoded         = '0;
    decoded.idx     = in_timer_index;
    decoded.idx_ok  = (32'(in_timer_index) < TIMER_COUNT);
    decoded.period  = in_new_period;
    decoded.restart = in_restart_count;
    unique case (in_op)
      OP_TICK:     decoded.op = OP_TICK;
      OP_START:    decoded.op = OP_START;
      OP_STOP:     decoded.op = OP_STOP;
      OP_STOP_ALL: decoded.op = OP_STOP_ALL;
      default:     decoded.op = OP_QUERY;  // Undefined codes behave as a query.
    endcase
  end

  assign in_stall   = front_valid_r && q_full;
  assign accept     = in_valid && !in_stall;
  assign push       = front_valid_r && !q_full;
  assign push_valid = push;
  assign push_cmd   = front_cmd_r;

  always_comb begin
    front_valid_nxt = front_valid_r;
    front_cmd_nxt   = front_cmd_r;
    if (push) begin
      front_valid_nxt = 1'b0;
    end
    if (accept) begin
      front_valid_nxt = 1'b1;
      front_cmd_nxt   = decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
    front_cmd_r <= front_cmd_nxt;
  end

endmodule

`default_nettype wire

>>> design/pstb_queue.sv
// Short command queue that decouples the front from the back of the timer bank.
// Uses cmd_t and QUEUE_DEPTH from pstb_pkg.
`default_nettype none

module pstb_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  input  wire pstb_pkg::cmd_t push_cmd,
  output logic                q_full,
  input  wire logic           pop,
  output logic                q_empty,
  output pstb_pkg::cmd_t      q_head
);
  import pstb_pkg::*;

  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t entry_r [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] fill_r, fill_nxt;
  logic do_push, do_pop;

  assign q_full  = (fill_r == QCW'(QUEUE_DEPTH));
  assign q_empty = (fill_r == '0);
  assign q_head  = entry_r[rd_ptr_r];
  assign do_push = push_valid && !q_full;
  assign do_pop  = pop && !q_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> design/pstb_mod.sv
// Bit-serial remainder unit: 32-bit count modulo 16-bit period, one bit a cycle.
// Uses DIV_STEPS from pstb_pkg.
`default_nettype none

module pstb_mod (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [15:0]      rem
);
  import pstb_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  logic          running_r, running_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [31:0]   dvd_r, dvd_nxt;
  logic [15:0]   dsr_r, dsr_nxt;
  logic [16:0]   trial;
  logic          fits;

  assign trial = {rem_r, dvd_r[31]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    running_nxt = running_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    dvd_nxt     = dvd_r;
    dsr_nxt     = dsr_r;
    if (start) begin
      running_nxt = 1'b1;
      cnt_nxt     = CW'(DIV_STEPS - 1);
      rem_nxt     = '0;
      dvd_nxt     = dividend;
      dsr_nxt     = divisor;
    end else if (running_r) begin
      // The partial remainder stays below the divisor, so 16 bits hold it.
      rem_nxt = fits ? 16'(trial - {1'b0, dsr_r}) : trial[15:0];
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        running_nxt = 1'b0;
        done_nxt    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      running_r <= running_nxt;
      done_r    <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

>>> design/pstb_back.sv
// Back end of the timer bank: holds the timer state, carries out each command,
// walks the timers on a tick and drives the result register. Uses pstb_pkg, pstb_mod.
`default_nettype none

module pstb_back #(
  parameter int TIMER_COUNT = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire pstb_pkg::cmd_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [3:0]          out_fired_mask,
  output logic [3:0]          out_stopped_mask,
  output logic                out_all_stopped,
  output logic [15:0]         out_eta_ticks,
  output logic [31:0]         out_tick_total
);
  import pstb_pkg::*;

  localparam int TW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [TW-1:0] LAST = TW'(TIMER_COUNT - 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_APPLY    = 7'b0000010,
    S_WALK     = 7'b0000100,
    S_WALK_DIV = 7'b0001000,
    S_ETA      = 7'b0010000,
    S_ETA_DIV  = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  cmd_t   cmd_r, cmd_nxt;
  logic [TW-1:0]          cur_r, cur_nxt;
  logic [MASK_BITS-1:0]   fired_r, fired_nxt;
  logic [15:0]            eta_r, eta_nxt;
  logic [31:0]            counts_r  [TIMER_COUNT];
  logic [31:0]            counts_nxt[TIMER_COUNT];
  logic [15:0]            periods_r  [TIMER_COUNT];
  logic [15:0]            periods_nxt[TIMER_COUNT];
  logic [TIMER_COUNT-1:0] stopped_r, stopped_nxt;
  logic [31:0]            ticks_r, ticks_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [MASK_BITS-1:0] out_fired_r, out_fired_nxt;
  logic [MASK_BITS-1:0] out_smask_r, out_smask_nxt;
  logic                 out_all_r, out_all_nxt;
  logic [15:0]          out_eta_r, out_eta_nxt;
  logic [31:0]          out_ticks_r, out_ticks_nxt;

  logic [TW-1:0]        idx_sel;
  logic [TW-1:0]        rd_sel;
  logic [31:0]          rd_count;
  logic [15:0]          rd_period;
  logic [MASK_BITS-1:0] smask;
  logic                 div_start;
  logic                 div_done;
  logic [15:0]          div_rem;

  assign idx_sel   = TW'(cmd_r.idx);
  // One read port: the walk position during a tick, the addressed timer afterwards.
  assign rd_sel    = (state_r == S_ETA || state_r == S_ETA_DIV) ? idx_sel : cur_r;
  assign rd_count  = counts_r[rd_sel];
  assign rd_period = periods_r[rd_sel];

  for (genvar k = 0; k < MASK_BITS; k++) begin : g_smask
    if (k < TIMER_COUNT) begin : g_live
      assign smask[k] = stopped_r[k];
    end else begin : g_none
      assign smask[k] = 1'b0;
    end
  end

  pstb_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_count),
    .divisor  (rd_period),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cur_nxt       = cur_r;
    fired_nxt     = fired_r;
    eta_nxt       = eta_r;
    counts_nxt    = counts_r;
    periods_nxt   = periods_r;
    stopped_nxt   = stopped_r;
    ticks_nxt     = ticks_r;
    q_pop         = 1'b0;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_fired_nxt = out_fired_r;
    out_smask_nxt = out_smask_r;
    out_all_nxt   = out_all_r;
    out_eta_nxt   = out_eta_r;
    out_ticks_nxt = out_ticks_r;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        fired_nxt = '0;
        state_nxt = S_ETA;
        unique case (cmd_r.op)
          OP_TICK: begin
            ticks_nxt = ticks_r + 32'd1;
            cur_nxt   = '0;
            state_nxt = S_WALK;
          end
          OP_START: begin
            if (cmd_r.idx_ok) begin
              periods_nxt[idx_sel] = cmd_r.period;
              stopped_nxt[idx_sel] = 1'b0;
              if (cmd_r.restart) begin
                counts_nxt[idx_sel] = '0;
              end
            end
          end
          OP_STOP: begin
            if (cmd_r.idx_ok) begin
              stopped_nxt[idx_sel] = 1'b1;
            end
          end
          OP_STOP_ALL: begin
            stopped_nxt = '1;
          end
          default: begin
          end
        endcase
      end
      S_WALK: begin
        if (stopped_r[cur_r]) begin
          if (cur_r == LAST) begin
            state_nxt = S_ETA;
          end else begin
            cur_nxt = cur_r + 1'b1;
          end
        end else if (rd_period == '0 || rd_count == '0) begin
          counts_nxt[cur_r] = rd_count + 32'd1;
          if (cur_r == LAST) begin
            state_nxt = S_ETA;
          end else begin
            cur_nxt = cur_r + 1'b1;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = S_WALK_DIV;
        end
      end
      S_WALK_DIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            fired_nxt = fired_r | (MASK_BITS'(1) << cur_r);
          end
          counts_nxt[cur_r] = rd_count + 32'd1;
          if (cur_r == LAST) begin
            state_nxt = S_ETA;
          end else begin
            cur_nxt   = cur_r + 1'b1;
            state_nxt = S_WALK;
          end
        end
      end
      S_ETA: begin
        if (!cmd_r.idx_ok || rd_period == '0) begin
          eta_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_ETA_DIV;
        end
      end
      S_ETA_DIV: begin
        if (div_done) begin
          eta_nxt   = rd_period - div_rem;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_fired_nxt = fired_r;
          out_smask_nxt = smask;
          out_all_nxt   = &stopped_r;
          out_eta_nxt   = eta_r;
          out_ticks_nxt = ticks_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      stopped_r   <= '1;
      ticks_r     <= '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
        counts_r[i]  <= '0;
        periods_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      stopped_r   <= stopped_nxt;
      ticks_r     <= ticks_nxt;
      counts_r    <= counts_nxt;
      periods_r   <= periods_nxt;
    end
    cmd_r       <= cmd_nxt;
    cur_r       <= cur_nxt;
    fired_r     <= fired_nxt;
    eta_r       <= eta_nxt;
    out_fired_r <= out_fired_nxt;
    out_smask_r <= out_smask_nxt;
    out_all_r   <= out_all_nxt;
    out_eta_r   <= out_eta_nxt;
    out_ticks_r <= out_ticks_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_fired_mask   = out_fired_r;
  assign out_stopped_mask = out_smask_r;
  assign out_all_stopped  = out_all_r;
  assign out_eta_ticks    = out_eta_r;
  assign out_tick_total   = out_ticks_r;

endmodule

`default_nettype wire
